// ===== rtl/core/smmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// smmtc_pkg: shared types and constants of the min/max threshold calibrator
// Holds store geometry, beat layouts, sequencer states and unit selects.
// ----------------------------------------------------------------------------
`default_nettype none

package smmtc_pkg;

  // Store geometry
  localparam int unsigned Channels = 8;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned IdxW     = (Channels > 1) ? $clog2(Channels) : 1;

  // Fixed field widths of the beats
  localparam int unsigned ChanW    = 3;
  localparam int unsigned SmpFldW  = 10;
  localparam int unsigned SpreadW  = 10;
  localparam int unsigned ThrW     = 10;
  localparam int unsigned DacW     = 15;

  // Shared unit width: widest operand plus a carry/borrow bit
  localparam int unsigned OperW    = (SampleW > SpreadW) ? SampleW : SpreadW;
  localparam int unsigned AluW     = OperW + 1;

  localparam logic [SpreadW-1:0] SpreadReset = SpreadW'(200);
  localparam logic [IdxW-1:0]    LastIdx     = IdxW'(Channels - 1);

  // Input beat
  typedef struct packed {
    logic               mode;
    logic [ChanW-1:0]   channel;
    logic [SmpFldW-1:0] sample;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic             passed;
    logic [ChanW-1:0] out_channel;
    logic [ThrW-1:0]  threshold;
    logic [DacW-1:0]  dac_word;
    logic             last;
  } result_t;

  // Input modes
  typedef enum logic {
    MODE_SAMPLE   = 1'b0,
    MODE_EVALUATE = 1'b1
  } mode_e;

  // Operand selection of the shared add/subtract unit
  typedef enum logic [2:0] {
    OPS_MAX_SMP,      // max - sample, borrow: sample is a new maximum
    OPS_SMP_MIN,      // sample - min, borrow: sample is a new minimum
    OPS_MAX_MIN,      // max - min, borrow: channel never sampled
    OPS_DIFF_SPREAD,  // spread - min_spread, borrow: spread too small
    OPS_MAX_PLUS_MIN  // max + min for the midpoint
  } opsel_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMP_MAX,
    ST_SMP_MIN,
    ST_CHK_DIFF,
    ST_CHK_CMP,
    ST_EMIT,
    ST_FAIL
  } state_e;

  // Control group from the sequencer to the datapath
  typedef struct packed {
    opsel_e opsel;
    logic   diff_en;
    logic   wr_max;
    logic   wr_min;
    logic   clear;
    logic   emit_pass;
    logic   emit_fail;
    logic   is_last;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/smmtc_alu.sv =====
// ----------------------------------------------------------------------------
// smmtc_alu: shared add/subtract unit
// Selects operands for the current step, adds or subtracts, and keeps the
// spread of the channel under check for the following compare step.
// ----------------------------------------------------------------------------
`default_nettype none

module smmtc_alu (
  input  wire                            clk_i,
  input  smmtc_pkg::opsel_e              opsel_i,
  input  wire                            diff_en_i,
  input  wire  [smmtc_pkg::SampleW-1:0]  rd_max_i,
  input  wire  [smmtc_pkg::SampleW-1:0]  rd_min_i,
  input  wire  [smmtc_pkg::SampleW-1:0]  smp_i,
  input  wire  [smmtc_pkg::SpreadW-1:0]  spread_i,
  output logic [smmtc_pkg::AluW-1:0]     res_o,
  output logic                           borrow_o
);
  import smmtc_pkg::*;

  logic [OperW-1:0] opa;
  logic [OperW-1:0] opb;
  logic             is_add;
  logic [AluW-1:0]  ext_a;
  logic [AluW-1:0]  ext_b;
  logic [OperW-1:0] diff_q;

  // Route operands for the current step
  always_comb begin
    opa    = '0;
    opb    = '0;
    is_add = 1'b0;
    case (opsel_i)
      OPS_MAX_SMP: begin
        opa = OperW'(rd_max_i);
        opb = OperW'(smp_i);
      end
      OPS_SMP_MIN: begin
        opa = OperW'(smp_i);
        opb = OperW'(rd_min_i);
      end
      OPS_MAX_MIN: begin
        opa = OperW'(rd_max_i);
        opb = OperW'(rd_min_i);
      end
      OPS_DIFF_SPREAD: begin
        opa = diff_q;
        opb = OperW'(spread_i);
      end
      OPS_MAX_PLUS_MIN: begin
        opa    = OperW'(rd_max_i);
        opb    = OperW'(rd_min_i);
        is_add = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Add or subtract; the top bit is carry or borrow
  assign ext_a    = {1'b0, opa};
  assign ext_b    = {1'b0, opb};
  assign res_o    = is_add ? (ext_a + ext_b) : (ext_a - ext_b);
  assign borrow_o = res_o[AluW-1];

  // Hold the spread for the compare step
  always_ff @(posedge clk_i) begin
    if (diff_en_i) begin
      diff_q <= res_o[OperW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smmtc_store.sv =====
// ----------------------------------------------------------------------------
// smmtc_store: per-channel maximum and minimum registers
// One read index, per-store write strobes, and a clear that sets every
// channel to max 0, min full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module smmtc_store (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [smmtc_pkg::IdxW-1:0]     idx_i,
  input  wire  [smmtc_pkg::SampleW-1:0]  wr_data_i,
  input  wire                            wr_max_i,
  input  wire                            wr_min_i,
  input  wire                            clear_i,
  output logic [smmtc_pkg::SampleW-1:0]  rd_max_o,
  output logic [smmtc_pkg::SampleW-1:0]  rd_min_o
);
  import smmtc_pkg::*;

  logic [SampleW-1:0] max_q [Channels];
  logic [SampleW-1:0] min_q [Channels];

  // Update, clear on a failed evaluate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Channels; k++) begin
        max_q[k] <= '0;
        min_q[k] <= '1;
      end
    end else if (clear_i) begin
      for (int k = 0; k < Channels; k++) begin
        max_q[k] <= '0;
        min_q[k] <= '1;
      end
    end else begin
      if (wr_max_i) begin
        max_q[idx_i] <= wr_data_i;
      end
      if (wr_min_i) begin
        min_q[idx_i] <= wr_data_i;
      end
    end
  end

  assign rd_max_o = max_q[idx_i];
  assign rd_min_o = min_q[idx_i];

  // A clear leaves every channel at its restart values
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (max_q[0] == '0 && min_q[0] == '1 &&
                 max_q[LastIdx] == '0 && min_q[LastIdx] == '1))
    else $error("store not restarted after clear");

endmodule

`default_nettype wire

// ===== rtl/core/smmtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// smmtc_ctrl: sequencer of the calibrator
// Steps a sample through max and min update, and an evaluate through a check
// pass, then an all-channel emit pass or a fail step, driving the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module smmtc_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  smmtc_pkg::in_item_t         item_i,
  input  wire                         borrow_i,
  output logic                        busy_o,
  output logic [smmtc_pkg::IdxW-1:0]  idx_o,
  output smmtc_pkg::ctrl_t            ctrl_o
);
  import smmtc_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;
  logic            chan_ok;
  logic            at_last;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign chan_ok = (32'(item_i.channel) < Channels);
  assign at_last = (idx_q == LastIdx);
  assign idx_o   = idx_q;

  // Next state and channel index
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.mode == MODE_EVALUATE) begin
            state_d = ST_CHK_DIFF;
            idx_d   = '0;
          end else if (chan_ok) begin
            state_d = ST_SMP_MAX;
            idx_d   = IdxW'(item_i.channel);
          end
        end
      end
      ST_SMP_MAX: begin
        state_d = ST_SMP_MIN;
      end
      ST_SMP_MIN: begin
        state_d = ST_IDLE;
      end
      ST_CHK_DIFF: begin
        state_d = borrow_i ? ST_FAIL : ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (borrow_i) begin
          state_d = ST_FAIL;
        end else if (at_last) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end else begin
          state_d = ST_CHK_DIFF;
          idx_d   = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (at_last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FAIL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs per state
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.opsel   = OPS_MAX_SMP;
    ctrl_o.is_last = at_last;
    case (state_q)
      ST_SMP_MAX: begin
        ctrl_o.opsel  = OPS_MAX_SMP;
        ctrl_o.wr_max = borrow_i;
      end
      ST_SMP_MIN: begin
        ctrl_o.opsel  = OPS_SMP_MIN;
        ctrl_o.wr_min = borrow_i;
      end
      ST_CHK_DIFF: begin
        ctrl_o.opsel   = OPS_MAX_MIN;
        ctrl_o.diff_en = 1'b1;
      end
      ST_CHK_CMP: begin
        ctrl_o.opsel = OPS_DIFF_SPREAD;
      end
      ST_EMIT: begin
        ctrl_o.opsel     = OPS_MAX_PLUS_MIN;
        ctrl_o.emit_pass = 1'b1;
      end
      ST_FAIL: begin
        ctrl_o.clear     = 1'b1;
        ctrl_o.emit_fail = 1'b1;
      end
      default: begin
        ctrl_o.opsel = OPS_MAX_SMP;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Emit pass starts only after every channel passed its compare
  a_emit_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |->
      ($past(state_q) == ST_CHK_CMP || $past(state_q) == ST_EMIT))
    else $error("emit entered without a full check pass");

  // Index stays inside the store while working
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (32'(idx_q) < Channels))
    else $error("channel index out of range");

  // No store writes while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !(ctrl_o.wr_max || ctrl_o.wr_min || ctrl_o.clear ||
                  ctrl_o.emit_pass || ctrl_o.emit_fail))
    else $error("store or result activity while idle");

endmodule

`default_nettype wire

// ===== rtl/core/sensor_min_max_threshold_calibrator.sv =====
// ----------------------------------------------------------------------------
// sensor_min_max_threshold_calibrator: min/max calibration of sensor channels
// Keeps running max and min per channel; an evaluate beat checks each
// channel's spread and gives either one fail beat or one threshold beat per
// channel.
// ----------------------------------------------------------------------------
// Usage: a beat is taken when start is high and busy is low. A sample beat
// keeps busy high through a max update, then a min update through the one
// shared add/subtract unit, so the next sample is taken only after both. An
// evaluate beat runs a check pass (spread, then compare with min_spread, per
// channel) and, if all pass, an emit pass over all channels, with the 8 result
// beats on done_o in the cycles after each emit step. A failing channel ends
// the check pass at once; a fail step follows, which restarts the stores, and
// the single fail beat is on done_o in the cycle after that step. Results are
// strobed for one cycle each and cannot be held off. The user must see that
// min_spread is written only while busy is low; the block does not enforce
// it.
`default_nettype none

module sensor_min_max_threshold_calibrator (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  smmtc_pkg::in_item_t            item_i,
  input  wire                            cfg_we_i,
  input  wire  [smmtc_pkg::SpreadW-1:0]  cfg_wdata_i,
  output logic                           done_o,
  output smmtc_pkg::result_t             result_o
);
  import smmtc_pkg::*;

  ctrl_t              ctrl;
  logic [IdxW-1:0]    idx;
  logic [SampleW-1:0] rd_max;
  logic [SampleW-1:0] rd_min;
  logic [AluW-1:0]    alu_res;
  logic               borrow;
  logic [SpreadW-1:0] spread_q;
  logic [SampleW-1:0] smp_q;
  logic               accept;
  logic [ThrW-1:0]    thr;
  result_t            res_q, res_d;
  logic               done_q, done_d;

  assign accept = start && !busy;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q <= SpreadReset;
    end else if (cfg_we_i) begin
      spread_q <= cfg_wdata_i;
    end
  end

  // Hold the sample of the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= SampleW'(item_i.sample);
    end
  end

  smmtc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (item_i),
    .borrow_i (borrow),
    .busy_o   (busy),
    .idx_o    (idx),
    .ctrl_o   (ctrl)
  );

  smmtc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (idx),
    .wr_data_i (smp_q),
    .wr_max_i  (ctrl.wr_max),
    .wr_min_i  (ctrl.wr_min),
    .clear_i   (ctrl.clear),
    .rd_max_o  (rd_max),
    .rd_min_o  (rd_min)
  );

  smmtc_alu u_alu (
    .clk_i     (clk_i),
    .opsel_i   (ctrl.opsel),
    .diff_en_i (ctrl.diff_en),
    .rd_max_i  (rd_max),
    .rd_min_i  (rd_min),
    .smp_i     (smp_q),
    .spread_i  (spread_q),
    .res_o     (alu_res),
    .borrow_o  (borrow)
  );

  // Midpoint is the sum without its low bit
  assign thr = ThrW'(alu_res[AluW-1:1]);

  // Build the result beat
  always_comb begin
    res_d  = res_q;
    done_d = ctrl.emit_pass || ctrl.emit_fail;
    if (ctrl.emit_pass) begin
      res_d.passed      = 1'b1;
      res_d.out_channel = ChanW'(idx);
      res_d.threshold   = thr;
      res_d.dac_word    = {ChanW'(idx), thr[ThrW-1:2], 4'b0000};
      res_d.last        = ctrl.is_last;
    end else if (ctrl.emit_fail) begin
      res_d      = '0;
      res_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A fail beat is alone and carries no threshold
  a_fail_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.passed) |->
      (result_o.last && result_o.threshold == '0 && result_o.dac_word == '0))
    else $error("malformed fail beat");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the min/max threshold calibrator
// Walks a short table of directed beats, then random calibration rounds
// under several min_spread settings. Every accepted beat runs through a local
// predictor of the per-channel max/min stores; each result beat is compared
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smmtc_pkg::*;

  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned DrainCyc   = 30;
  localparam int unsigned RandTarget = 350;

  typedef struct {
    bit                 is_cfg;
    logic [SpreadW-1:0] cfg_val;
    in_item_t           item;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  // DUT connections, known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  in_item_t           item_i      = '0;
  logic               cfg_we_i    = 1'b0;
  logic [SpreadW-1:0] cfg_wdata_i = '0;
  logic               done_o;
  result_t            result_o;

  // Predictor state
  logic [SampleW-1:0] cal_max [Channels];
  logic [SampleW-1:0] cal_min [Channels];
  logic [SpreadW-1:0] cal_spread;

  result_t     pending_results [$];
  int unsigned idle_cycles = 0;
  int unsigned n_errors    = 0;
  int unsigned n_beats     = 0;
  int unsigned n_evals     = 0;
  int unsigned n_eval_pass = 0;
  int unsigned n_eval_fail = 0;
  int unsigned n_results   = 0;
  int unsigned n_settings  = 0;

  sensor_min_max_threshold_calibrator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Restart the stores: max empty, min full scale
  function automatic void clear_cal_stores();
    for (int k = 0; k < Channels; k++) begin
      cal_max[k] = '0;
      cal_min[k] = '1;
    end
  endfunction

  // Compute the result beats one input beat causes and advance the stores
  function automatic void calib_predict(input in_item_t it, output result_t res[$]);
    bit              fail;
    logic [SampleW:0] sum;
    logic [ThrW-1:0] thr;
    result_t         r;
    res = {};
    fail = 1'b0;
    if (it.mode == MODE_SAMPLE) begin
      if (int'(it.channel) < Channels) begin
        if (cal_max[it.channel] < it.sample) cal_max[it.channel] = it.sample;
        if (cal_min[it.channel] > it.sample) cal_min[it.channel] = it.sample;
      end
      return;
    end
    for (int k = 0; k < Channels; k++) begin
      if (cal_max[k] < cal_min[k]) fail = 1'b1;
      else if ((cal_max[k] - cal_min[k]) < cal_spread) fail = 1'b1;
    end
    if (fail) begin
      r = '0;
      r.last = 1'b1;
      res.push_back(r);
      clear_cal_stores();
      return;
    end
    for (int k = 0; k < Channels; k++) begin
      sum = {1'b0, cal_max[k]} + {1'b0, cal_min[k]};
      thr = sum[SampleW:1];
      r.passed      = 1'b1;
      r.out_channel = ChanW'(k);
      r.threshold   = thr;
      r.dac_word    = DacW'(((k << 12) & 'h7000) | (((int'(thr) >> 2) << 4) & 'h0FF0));
      r.last        = (k == Channels - 1);
      res.push_back(r);
    end
  endfunction

  // Present one beat after a gap, hold it until taken, queue its results
  task automatic send_beat(input in_item_t it, input int gap, input bit typed,
                           input result_t want);
    result_t res [$];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    calib_predict(it, res);
    n_beats++;
    if (it.mode == MODE_EVALUATE) begin
      n_evals++;
      if (res[0].passed) n_eval_pass++;
      else n_eval_fail++;
    end
    if (typed) pending_results.push_back(want);
    else foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // Drop start and wait until every pending result has come and busy is low
  task automatic settle_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Write min_spread while the block is idle
  task automatic program_spread(input logic [SpreadW-1:0] v);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cal_spread = v;
    n_settings++;
  endtask

  function automatic stim_row_t beat_row(input logic m, input int ch, input int s);
    stim_row_t row;
    row = '{default: '0};
    row.item.mode    = m;
    row.item.channel = ChanW'(ch);
    row.item.sample  = SmpFldW'(s);
    return row;
  endfunction

  function automatic stim_row_t fail_row(input int ch, input int s);
    stim_row_t row;
    row = beat_row(MODE_EVALUATE, ch, s);
    row.typed     = 1'b1;
    row.want      = '0;
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input int v);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = SpreadW'(v);
    return row;
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %p", result_o);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o.passed !== exp_r.passed) begin
          $error("passed: expected %0d, got %0d", exp_r.passed, result_o.passed);
          n_errors++;
        end
        if (result_o.out_channel !== exp_r.out_channel) begin
          $error("out_channel: expected %0d, got %0d", exp_r.out_channel,
                 result_o.out_channel);
          n_errors++;
        end
        if (result_o.threshold !== exp_r.threshold) begin
          $error("threshold: expected %0d, got %0d", exp_r.threshold, result_o.threshold);
          n_errors++;
        end
        if (result_o.dac_word !== exp_r.dac_word) begin
          $error("dac_word: expected 'h%0h, got 'h%0h", exp_r.dac_word, result_o.dac_word);
          n_errors++;
        end
        if (result_o.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, result_o.last);
          n_errors++;
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("sensor_min_max_threshold_calibrator verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   rows [$];
    in_item_t    round [$];
    in_item_t    it, tmp;
    int          spreads [$];
    int          want, lo, hi, j, n, phase, rand_beats;
    bit          no_idle;
    result_t     none;

    none = '0;
    clear_cal_stores();
    cal_spread = SpreadReset;

    // Hold reset, then release on a rising edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset state, never-sampled channels, extremes
    rows.push_back(fail_row(0, 0));
    rows.push_back(cfg_row(0));
    rows.push_back(fail_row(7, 1023));
    rows.push_back(beat_row(MODE_SAMPLE, 0, 0));
    rows.push_back(beat_row(MODE_SAMPLE, 1, 1023));
    rows.push_back(beat_row(MODE_SAMPLE, 2, 'h155));
    rows.push_back(beat_row(MODE_SAMPLE, 3, 'h2AA));
    rows.push_back(beat_row(MODE_SAMPLE, 4, 1));
    rows.push_back(beat_row(MODE_SAMPLE, 5, 1022));
    rows.push_back(beat_row(MODE_SAMPLE, 6, 512));
    rows.push_back(beat_row(MODE_SAMPLE, 7, 511));
    rows.push_back(beat_row(MODE_EVALUATE, 5, 'h2AA));
    rows.push_back(beat_row(MODE_SAMPLE, 0, 1023));
    rows.push_back(beat_row(MODE_SAMPLE, 7, 1023));
    rows.push_back(beat_row(MODE_SAMPLE, 7, 0));
    rows.push_back(beat_row(MODE_EVALUATE, 0, 0));
    rows.push_back(cfg_row(1023));
    rows.push_back(beat_row(MODE_EVALUATE, 3, 'h155));
    rows.push_back(cfg_row(200));
    rows.push_back(fail_row(2, 77));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) program_spread(rows[i].cfg_val);
      else send_beat(rows[i].item, $urandom_range(0, 4), rows[i].typed, rows[i].want);
    end

    // Random calibration rounds over several min_spread settings
    spreads = '{0, 1023, 200, 1, -1, 512, -1, 1022};
    rand_beats = 0;
    phase = 0;
    while (rand_beats < RandTarget) begin
      if (spreads[phase % spreads.size()] < 0) begin
        program_spread(SpreadW'($urandom_range(0, 1023)));
      end else begin
        program_spread(SpreadW'(spreads[phase % spreads.size()]));
      end
      for (int r = 0; r < 3; r++) begin
        round = {};
        no_idle = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0) begin
          // Noise: arbitrary beats, evaluates now and then
          n = $urandom_range(4, 16);
          for (int b = 0; b < n; b++) begin
            it.mode    = ($urandom_range(0, 7) == 0) ? MODE_EVALUATE : MODE_SAMPLE;
            it.channel = ChanW'($urandom_range(0, 7));
            it.sample  = SmpFldW'($urandom_range(0, 1023));
            round.push_back(it);
          end
        end else begin
          // Well-formed: bracket channels around min_spread, each skipped now and then, then evaluate
          for (int k = 0; k < Channels; k++) begin
            if ($urandom_range(0, 11) != 0) begin
              want = int'(cal_spread) + int'($urandom_range(0, 40)) - 20;
              if (want < 0) want = 0;
              if (want > 1023) want = 1023;
              lo = $urandom_range(0, 1023 - want);
              hi = lo + want;
              it.mode    = MODE_SAMPLE;
              it.channel = ChanW'(k);
              it.sample  = SmpFldW'(lo);
              round.push_back(it);
              it.sample  = SmpFldW'(hi);
              round.push_back(it);
              if ($urandom_range(0, 2) == 0) begin
                it.sample = SmpFldW'($urandom_range(lo, hi));
                round.push_back(it);
              end
            end
          end
          // Shuffle so channels interleave
          for (int a = round.size() - 1; a > 0; a--) begin
            j = $urandom_range(0, a);
            tmp = round[a];
            round[a] = round[j];
            round[j] = tmp;
          end
          it.mode    = MODE_EVALUATE;
          it.channel = ChanW'($urandom_range(0, 7));
          it.sample  = SmpFldW'($urandom_range(0, 1023));
          round.push_back(it);
        end
        foreach (round[b]) begin
          send_beat(round[b], no_idle ? 0 : $urandom_range(0, 4), 1'b0, none);
          rand_beats++;
        end
        // Hold off now and then until all results are in
        if ($urandom_range(0, 5) == 0) settle_idle();
      end
      phase++;
    end

    // Drain the pending results, then let the block settle
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCyc) @(posedge clk_i);

    $display("Ran %0d beats with %0d evaluates (%0d passed, %0d failed calibration)",
             n_beats, n_evals, n_eval_pass, n_eval_fail);
    $display("Checked %0d result beats across %0d min_spread writes, %0d mismatches",
             n_results, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("sensor_min_max_threshold_calibrator verification clean");
    end else begin
      $display("sensor_min_max_threshold_calibrator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/smmtc_pkg.sv
rtl/core/smmtc_alu.sv
rtl/core/smmtc_store.sv
rtl/core/smmtc_ctrl.sv
rtl/core/sensor_min_max_threshold_calibrator.sv
tb/tb_top.sv
